// File: design/kwm_pkg.sv
// Package for the k-way sorted run merge: sizes, codes, item and control structs.
package kwm_pkg;

  localparam int NUM_RUNS  = 8;
  localparam int RUN_DEPTH = 1024;

  localparam int RUN_W  = $clog2(NUM_RUNS);
  localparam int ADDR_W = $clog2(RUN_DEPTH);
  localparam int FILL_W = $clog2(RUN_DEPTH + 1);
  localparam int DATA_W = 32;

  localparam logic [1:0] REQ_LOAD  = 2'd0;
  localparam logic [1:0] REQ_PULL  = 2'd1;
  localparam logic [1:0] REQ_CLEAR = 2'd2;

  localparam logic [2:0] ST_LOADED  = 3'd0;
  localparam logic [2:0] ST_MERGED  = 3'd1;
  localparam logic [2:0] ST_EMPTY   = 3'd2;
  localparam logic [2:0] ST_FULL    = 3'd3;
  localparam logic [2:0] ST_CLEARED = 3'd4;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [2:0]         run_index;
    logic signed [31:0] value;
  } in_item_t;

  typedef struct packed {
    logic [2:0]         status;
    logic signed [31:0] merged_value;
    logic [2:0]         source_run;
  } out_item_t;

  // best head seen so far, handed from cell to cell
  typedef struct packed {
    logic                     valid;
    logic signed [DATA_W-1:0] value;
    logic [RUN_W-1:0]         run;
  } cand_t;

  typedef struct packed {
    logic              load;
    logic              clear;
    logic              adv;
    logic [DATA_W-1:0] value;
  } cell_ctl_t;

endpackage

// File: design/k_way_sorted_run_merge.sv
// Top level of the k-way sorted run merge: request control and the row of run cells.
// Each run lives in a cell with its own RAM and fill/read counters. A load or a clear
// leaves busy low: the next item may start in the following cycle. A pull runs the
// heads through the chain of cells, one cell per cycle, so it keeps busy high through
// the scan and the done state; the next item can be accepted once the block is back
// in idle. Each result shows for one cycle with done high, in the cycle after the
// item's work ends; the receiver cannot stall it and must take it then. There is no
// clearing pass after reset.
module k_way_sorted_run_merge (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  kwm_pkg::in_item_t  cmd,
  output logic               done,
  output kwm_pkg::out_item_t result
);

  kwm_pkg::state_t           state;
  kwm_pkg::state_t           state_next;
  logic [kwm_pkg::RUN_W-1:0] cnt;
  logic [kwm_pkg::RUN_W-1:0] cnt_next;
  logic                      done_next;
  kwm_pkg::out_item_t        result_next;

  logic                      accept;
  logic [kwm_pkg::NUM_RUNS-1:0] hit;
  logic [kwm_pkg::NUM_RUNS-1:0] full;
  logic [kwm_pkg::NUM_RUNS-1:0] adv;
  logic                      full_sel;
  logic                      do_load;
  logic                      do_clear;
  logic                      do_adv;

  kwm_pkg::cand_t chain [kwm_pkg::NUM_RUNS+1];
  kwm_pkg::cand_t win;

  assign accept = start && !busy;
  assign busy   = (state != kwm_pkg::S_IDLE);
  assign win    = chain[kwm_pkg::NUM_RUNS];

  always_comb begin
    full_sel = 1'b0;
    for (int i = 0; i < kwm_pkg::NUM_RUNS; i++) begin
      hit[i]   = (32'(cmd.run_index) == i);
      full_sel = full_sel | (hit[i] & full[i]);
    end
  end

  assign chain[0] = '0;

  for (genvar g = 0; g < kwm_pkg::NUM_RUNS; g++) begin : g_cell
    kwm_pkg::cell_ctl_t ctl;

    assign ctl.load  = do_load && hit[g];
    assign ctl.clear = do_clear;
    assign ctl.adv   = do_adv && (win.run == kwm_pkg::RUN_W'(g));
    assign ctl.value = cmd.value;
    assign adv[g]    = ctl.adv;

    kwm_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .idx     (kwm_pkg::RUN_W'(g)),
      .ctl     (ctl),
      .cand_in (chain[g]),
      .cand_out(chain[g+1]),
      .full    (full[g])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= kwm_pkg::S_IDLE;
      cnt   <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      done  <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    result <= result_next;
  end

  always_comb begin
    state_next  = state;
    cnt_next    = cnt;
    done_next   = 1'b0;
    result_next = '0;
    do_load     = 1'b0;
    do_clear    = 1'b0;
    do_adv      = 1'b0;
    unique case (state)
      kwm_pkg::S_IDLE: begin
        cnt_next = '0;
        if (accept) begin
          case (cmd.req_type)
            kwm_pkg::REQ_LOAD: begin
              done_next = 1'b1;
              // an index past the last run hits no cell and reads as full
              if ((|hit) && !full_sel) begin
                do_load            = 1'b1;
                result_next.status = kwm_pkg::ST_LOADED;
              end else begin
                result_next.status = kwm_pkg::ST_FULL;
              end
            end
            kwm_pkg::REQ_PULL: begin
              state_next = kwm_pkg::S_SCAN;
            end
            kwm_pkg::REQ_CLEAR: begin
              do_clear           = 1'b1;
              done_next          = 1'b1;
              result_next.status = kwm_pkg::ST_CLEARED;
            end
            default: begin
            end
          endcase
        end
      end
      kwm_pkg::S_SCAN: begin
        // the best head passes through the registered cells to reach the end of the chain
        cnt_next = cnt + 1'b1;
        if (cnt == kwm_pkg::RUN_W'(kwm_pkg::NUM_RUNS - 1)) begin
          state_next = kwm_pkg::S_DONE;
        end
      end
      kwm_pkg::S_DONE: begin
        state_next = kwm_pkg::S_IDLE;
        done_next  = 1'b1;
        if (win.valid) begin
          do_adv                   = 1'b1;
          result_next.status       = kwm_pkg::ST_MERGED;
          result_next.merged_value = win.value;
          result_next.source_run   = 3'(win.run);
        end else begin
          result_next.status = kwm_pkg::ST_EMPTY;
        end
      end
      default: begin
        state_next = kwm_pkg::S_IDLE;
      end
    endcase
  end

`ifndef NO_ASSERTIONS
  a_adv_onehot: assert property (@(posedge clk) disable iff (rst) $onehot0(adv))
    else $error("more than one run advanced");
  a_no_done_in_scan: assert property (@(posedge clk) disable iff (rst)
    state == kwm_pkg::S_SCAN |-> !done)
    else $error("result strobe during scan");
  a_merge_after_done: assert property (@(posedge clk) disable iff (rst)
    done && result.status == kwm_pkg::ST_MERGED |-> $past(state) == kwm_pkg::S_DONE)
    else $error("merged result without finished scan");
  a_done_to_idle: assert property (@(posedge clk) disable iff (rst)
    state == kwm_pkg::S_DONE |=> state == kwm_pkg::S_IDLE && done)
    else $error("pull did not finish with a result");
`endif

endmodule

// File: design/kwm_ram.sv
// Generic single-write, single-read RAM with registered read data.
module kwm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: design/kwm_cell.sv
// One run: storage, fill and read counters, and one stage of the min-compare chain.
module kwm_cell (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [kwm_pkg::RUN_W-1:0]     idx,
  input  kwm_pkg::cell_ctl_t            ctl,
  input  kwm_pkg::cand_t                cand_in,
  output kwm_pkg::cand_t                cand_out,
  output logic                          full
);

  logic [kwm_pkg::FILL_W-1:0] fill;
  logic [kwm_pkg::FILL_W-1:0] rd_pos;
  logic [kwm_pkg::DATA_W-1:0] head;
  logic                       head_ok;
  kwm_pkg::cand_t             cand_next;

  kwm_ram #(
    .WIDTH(kwm_pkg::DATA_W),
    .DEPTH(kwm_pkg::RUN_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ctl.load),
    .waddr(fill[kwm_pkg::ADDR_W-1:0]),
    .wdata(ctl.value),
    .raddr(rd_pos[kwm_pkg::ADDR_W-1:0]),
    .rdata(head)
  );

  assign full    = (fill == kwm_pkg::FILL_W'(kwm_pkg::RUN_DEPTH));
  assign head_ok = (rd_pos < fill);

  // strict less keeps the lower run on ties
  always_comb begin
    cand_next = cand_in;
    if (head_ok && (!cand_in.valid || ($signed(head) < cand_in.value))) begin
      cand_next.valid = 1'b1;
      cand_next.value = $signed(head);
      cand_next.run   = idx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill           <= '0;
      rd_pos         <= '0;
      cand_out.valid <= 1'b0;
    end else begin
      if (ctl.clear) begin
        fill   <= '0;
        rd_pos <= '0;
      end else begin
        if (ctl.load) begin
          fill <= fill + 1'b1;
        end
        if (ctl.adv) begin
          rd_pos <= rd_pos + 1'b1;
        end
      end
      cand_out.valid <= cand_next.valid;
    end
    cand_out.value <= cand_next.value;
    cand_out.run   <= cand_next.run;
  end

endmodule

// File: sim/tb.sv
// Testbench for k_way_sorted_run_merge: directed and random items checked against a merge predictor.
`timescale 1ns / 1ps

module tb;

  localparam logic [1:0] REQ_UNUSED  = 2'd3;
  localparam int         STALL_LIMIT = 1000;
  localparam int         RAND_ITEMS  = 650;

  logic               clk;
  logic               rst;
  logic               start;
  logic               busy;
  kwm_pkg::in_item_t  cmd;
  logic               done;
  kwm_pkg::out_item_t result;

  k_way_sorted_run_merge dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .cmd    (cmd),
    .done   (done),
    .result (result)
  );

  // predictor state
  logic signed [31:0] run_mem [kwm_pkg::NUM_RUNS][kwm_pkg::RUN_DEPTH];
  int                 run_fill [kwm_pkg::NUM_RUNS];
  int                 run_pos [kwm_pkg::NUM_RUNS];
  longint             run_tail [kwm_pkg::NUM_RUNS];

  kwm_pkg::out_item_t pending_results [$];
  kwm_pkg::out_item_t want;
  int                 errors;
  int                 stall_cycles;
  bit                 idle_on;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic bit predict_merge(input kwm_pkg::in_item_t c,
                                       output kwm_pkg::out_item_t r);
    bit                 found;
    logic signed [31:0] best;
    logic signed [31:0] head;
    logic [2:0]         best_run;
    r        = '0;
    found    = 1'b0;
    best     = '0;
    best_run = '0;
    case (c.req_type)
      kwm_pkg::REQ_LOAD: begin
        if (c.run_index >= kwm_pkg::NUM_RUNS ||
            run_fill[c.run_index] >= kwm_pkg::RUN_DEPTH) begin
          r.status = kwm_pkg::ST_FULL;
        end else begin
          run_mem[c.run_index][run_fill[c.run_index]] = c.value;
          run_fill[c.run_index]++;
          r.status = kwm_pkg::ST_LOADED;
        end
      end
      kwm_pkg::REQ_PULL: begin
        for (int i = 0; i < kwm_pkg::NUM_RUNS; i++) begin
          if (run_pos[i] < run_fill[i]) begin
            head = run_mem[i][run_pos[i]];
            // strict less keeps the lowest run on ties
            if (!found || head < best) begin
              found    = 1'b1;
              best     = head;
              best_run = i[2:0];
            end
          end
        end
        if (!found) begin
          r.status = kwm_pkg::ST_EMPTY;
        end else begin
          run_pos[best_run]++;
          r.status       = kwm_pkg::ST_MERGED;
          r.merged_value = best;
          r.source_run   = best_run;
        end
      end
      kwm_pkg::REQ_CLEAR: begin
        for (int i = 0; i < kwm_pkg::NUM_RUNS; i++) begin
          run_fill[i] = 0;
          run_pos[i]  = 0;
        end
        r.status = kwm_pkg::ST_CLEARED;
      end
      default: return 1'b0;
    endcase
    return 1'b1;
  endfunction

  task automatic send_cmd(input logic [1:0] rt, input logic [2:0] ri,
                          input logic signed [31:0] v);
    kwm_pkg::in_item_t  c;
    kwm_pkg::out_item_t r;
    c.req_type  = rt;
    c.run_index = ri;
    c.value     = v;
    if (idle_on && $urandom_range(99) < 32) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 2)) @(posedge clk);
    end
    start <= 1'b1;
    cmd   <= c;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (predict_merge(c, r)) pending_results.push_back(r);
  endtask

  // next ascending value for run r, saturating at the top of the range
  function automatic logic signed [31:0] next_tail(input int r, input int step);
    longint v;
    v = run_tail[r] + longint'($urandom_range(0, step));
    if (v > 64'sd2147483647) v = 64'sd2147483647;
    run_tail[r] = v;
    return v[31:0];
  endfunction

  task automatic test_empty_pull();
    send_cmd(kwm_pkg::REQ_PULL, 3'd5, 32'sd77);
    send_cmd(kwm_pkg::REQ_PULL, 3'd0, -32'sd1);
    send_cmd(kwm_pkg::REQ_CLEAR, 3'd7, 32'sd0);
    send_cmd(REQ_UNUSED, 3'd2, 32'sd9);
    send_cmd(kwm_pkg::REQ_PULL, 3'd7, 32'sd0);
  endtask

  task automatic test_extremes();
    send_cmd(kwm_pkg::REQ_LOAD, 3'd0, 32'sh8000_0000);
    send_cmd(kwm_pkg::REQ_LOAD, 3'd0, 32'sh7fff_ffff);
    send_cmd(kwm_pkg::REQ_LOAD, 3'd7, -32'sd1);
    send_cmd(kwm_pkg::REQ_LOAD, 3'd7, 32'sd0);
    send_cmd(kwm_pkg::REQ_LOAD, 3'd4, 32'sh7fff_ffff);
    repeat (6) send_cmd(kwm_pkg::REQ_PULL, 3'd0, 32'sd0);
    send_cmd(kwm_pkg::REQ_CLEAR, 3'd0, 32'sd0);
  endtask

  task automatic test_ties();
    send_cmd(kwm_pkg::REQ_LOAD, 3'd5, 32'sd42);
    send_cmd(kwm_pkg::REQ_LOAD, 3'd2, 32'sd42);
    send_cmd(kwm_pkg::REQ_LOAD, 3'd7, 32'sd42);
    send_cmd(kwm_pkg::REQ_LOAD, 3'd0, 32'sd42);
    send_cmd(REQ_UNUSED, 3'd0, 32'sd0);
    repeat (5) send_cmd(kwm_pkg::REQ_PULL, 3'd3, 32'sd0);
    send_cmd(kwm_pkg::REQ_CLEAR, 3'd0, 32'sd0);
  endtask

  task automatic test_out_of_order();
    send_cmd(kwm_pkg::REQ_LOAD, 3'd1, 32'sd10);
    send_cmd(kwm_pkg::REQ_LOAD, 3'd1, 32'sd3);
    send_cmd(kwm_pkg::REQ_LOAD, 3'd2, 32'sd5);
    repeat (4) send_cmd(kwm_pkg::REQ_PULL, 3'd0, 32'sd0);
    send_cmd(kwm_pkg::REQ_CLEAR, 3'd0, 32'sd0);
  endtask

  // fill one run to the brim; pulls must not make room again
  task automatic test_full_run();
    for (int k = 0; k < kwm_pkg::RUN_DEPTH; k++) begin
      send_cmd(kwm_pkg::REQ_LOAD, 3'd3, 32'(k * 7 - 3000));
    end
    send_cmd(kwm_pkg::REQ_LOAD, 3'd3, 32'sh7fff_ffff);
    repeat (3) send_cmd(kwm_pkg::REQ_PULL, 3'd0, 32'sd0);
    send_cmd(kwm_pkg::REQ_LOAD, 3'd3, 32'sd1);
    send_cmd(kwm_pkg::REQ_LOAD, 3'd4, -32'sd5000);
    repeat (2) send_cmd(kwm_pkg::REQ_PULL, 3'd0, 32'sd0);
    send_cmd(kwm_pkg::REQ_CLEAR, 3'd0, 32'sd0);
    send_cmd(kwm_pkg::REQ_LOAD, 3'd3, 32'sd1);
    send_cmd(kwm_pkg::REQ_PULL, 3'd0, 32'sd0);
    send_cmd(kwm_pkg::REQ_CLEAR, 3'd0, 32'sd0);
  endtask

  task automatic noise_cmd();
    case ($urandom_range(2))
      0:       send_cmd(REQ_UNUSED, 3'($urandom_range(7)), 32'($urandom()));
      1:       send_cmd(kwm_pkg::REQ_LOAD, 3'($urandom_range(7)), 32'($urandom()));
      default: send_cmd(kwm_pkg::REQ_CLEAR, 3'($urandom_range(7)), 32'($urandom()));
    endcase
  endtask

  // clear, load mostly ascending runs with random content, then pull n + 2 times with loads mixed in
  task automatic test_random_merge();
    int     sent;
    int     seq;
    int     n;
    int     pulls;
    int     r;
    int     step;
    int     k;
    longint base;
    sent = 0;
    seq  = 0;
    while (sent < RAND_ITEMS) begin
      idle_on = !(seq >= 2 && seq < 5);
      case ($urandom_range(3))
        0:       step = 0;
        1:       step = 3;
        2:       step = 1000;
        default: step = 1 << 24;
      endcase
      case ($urandom_range(7))
        0:       base = -64'sd2147483648;
        1:       base = 64'sd2147483647 - longint'($urandom_range(0, 50));
        default: base = longint'($signed($urandom()));
      endcase
      for (int i = 0; i < kwm_pkg::NUM_RUNS; i++) run_tail[i] = base;
      send_cmd(kwm_pkg::REQ_CLEAR, 3'($urandom_range(7)), 32'($urandom()));
      sent++;
      n = $urandom_range(4, 40);
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(99) < 6) begin
          noise_cmd();
        end else begin
          r = $urandom_range(7);
          send_cmd(kwm_pkg::REQ_LOAD, 3'(r), next_tail(r, step));
        end
        sent++;
      end
      pulls = 0;
      while (pulls < n + 2) begin
        k = $urandom_range(99);
        if (k < 10) begin
          r = $urandom_range(7);
          send_cmd(kwm_pkg::REQ_LOAD, 3'(r), next_tail(r, step));
        end else if (k < 14) begin
          noise_cmd();
        end else begin
          send_cmd(kwm_pkg::REQ_PULL, 3'($urandom_range(7)), 32'($urandom()));
          pulls++;
        end
        sent++;
      end
      seq++;
    end
    idle_on = 1'b1;
  endtask

  // result checker
  always @(posedge clk) begin
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, actual %p", $time, result);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (result.status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, result.status);
          errors++;
        end
        if (result.merged_value !== want.merged_value) begin
          $display("%0t: merged_value expected %0d actual %0d", $time,
                   want.merged_value, result.merged_value);
          errors++;
        end
        if (result.source_run !== want.source_run) begin
          $display("%0t: source_run expected %0d actual %0d", $time,
                   want.source_run, result.source_run);
          errors++;
        end
      end
    end
  end

  // watchdog on cycles without any accepted item or result
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: timeout, no activity for %0d cycles", $time, STALL_LIMIT);
      $display("CHECKS FAILED");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    errors       = 0;
    stall_cycles = 0;
    idle_on      = 1'b1;
    for (int i = 0; i < kwm_pkg::NUM_RUNS; i++) begin
      run_fill[i] = 0;
      run_pos[i]  = 0;
      run_tail[i] = 0;
    end
    rst   <= 1'b1;
    start <= 1'b0;
    cmd   <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    test_empty_pull();
    test_extremes();
    test_ties();
    test_out_of_order();
    test_full_run();
    test_random_merge();

    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (kwm_pkg::NUM_RUNS + 4) @(posedge clk);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
